@@ src/mpsm_pkg.sv @@
// Shared types and constants for the multi-pattern string matcher.
`default_nettype none

package mpsm_pkg;

    localparam int MAX_STATES_DEF = 256;
    localparam int ALPHABET_DEF   = 64;
    localparam int MAX_WORDS_DEF  = 32;

    localparam logic [7:0] LOWEST_CHAR_RST  = 8'd97;
    localparam logic [7:0] HIGHEST_CHAR_RST = 8'd122;

    // Item kinds
    localparam logic [2:0] KIND_CLEAR = 3'd0;
    localparam logic [2:0] KIND_KEY   = 3'd1;
    localparam logic [2:0] KIND_END   = 3'd2;
    localparam logic [2:0] KIND_BUILD = 3'd3;
    localparam logic [2:0] KIND_TEXT  = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_SPAN  = 2'd2;
    localparam logic [1:0] STAT_WORDS = 2'd3;

    // Configuration register indexes
    localparam logic REG_LOWEST  = 1'b0;
    localparam logic REG_HIGHEST = 1'b1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] symbol;
    } item_t;

    typedef struct packed {
        logic [7:0]  state;
        logic [31:0] match_mask;
        logic [8:0]  state_count;
        logic [1:0]  status;
    } result_t;

endpackage

`default_nettype wire

@@ src/multi_pattern_string_matcher_unit.sv @@
// Top level of the Aho-Corasick multi-keyword matcher.
`default_nettype none

// Usage:
// Items arrive on item/item_valid/item_ready and each produces exactly one
// transfer on result/result_valid/result_ready. Register writes come on
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high.
// The trie lives in four synchronous-read memories: goto (MAX_STATES *
// ALPHABET entries, zero meaning absent), failure link, output mask and the
// breadth-first queue. One item is processed at a time by a sequencer that
// reads, modifies and writes these memories.
// A keyword char reads then writes goto; an end keyword reads then writes the
// output mask; a text char follows failure links until a goto hit, then reads
// the output mask; a build scans the root row, then for each queued node reads
// its failure link and row and follows failure links for each child found.
// The goto memory's single read port sets the pace of the walks.
// Reset: a clearing pass sweeps the goto, failure-link and mask memories;
// item_ready stays low during it. A clear item runs the same pass.
// Stalls: a finished result waits in the output register while the next
// item is already accepted; the sequencer holds at its last step until the
// output register frees up.

module multi_pattern_string_matcher_unit #(
    parameter int MAX_STATES = mpsm_pkg::MAX_STATES_DEF,
    parameter int ALPHABET   = mpsm_pkg::ALPHABET_DEF,
    parameter int MAX_WORDS  = mpsm_pkg::MAX_WORDS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire mpsm_pkg::item_t  item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output mpsm_pkg::result_t     result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [7:0]       cfg_data
);

    localparam int SW     = $clog2(MAX_STATES);
    localparam int CW     = $clog2(ALPHABET);
    localparam int GDEPTH = MAX_STATES * ALPHABET;
    localparam int GW     = $clog2(GDEPTH);
    localparam int MW     = MAX_WORDS;
    localparam int WCW    = $clog2(MAX_WORDS + 1);

    localparam logic [GW-1:0]  ALPHA_G   = GW'(ALPHABET);
    localparam logic [GW-1:0]  CLR_LAST  = GW'(GDEPTH - 1);
    localparam logic [GW-1:0]  STATES_G  = GW'(MAX_STATES);
    localparam logic [SW:0]    STATES_N  = (SW + 1)'(MAX_STATES);
    localparam logic [CW-1:0]  COL_LAST  = CW'(ALPHABET - 1);
    localparam logic [8:0]     ALPHA_9   = 9'(ALPHABET);
    localparam logic [WCW-1:0] WORDS_N   = WCW'(MAX_WORDS);

    typedef enum logic [20:0] {
        S_IDLE     = 21'h000001,
        S_CLR      = 21'h000002,
        S_KW_RD    = 21'h000004,
        S_KW_WR    = 21'h000008,
        S_EK_RD    = 21'h000010,
        S_EK_WR    = 21'h000020,
        S_ADV_RD   = 21'h000040,
        S_ADV_CHK  = 21'h000080,
        S_FAIL_CHK = 21'h000100,
        S_MR       = 21'h000200,
        S_MD       = 21'h000400,
        S_BM_CD    = 21'h000800,
        S_BR_RD    = 21'h001000,
        S_BR_CHK   = 21'h002000,
        S_BQ_CHK   = 21'h004000,
        S_BQ_S     = 21'h008000,
        S_BQ_F     = 21'h010000,
        S_BQ_FS    = 21'h020000,
        S_BC_RD    = 21'h040000,
        S_BC_CHK   = 21'h080000,
        S_FIN      = 21'h100000
    } seq_t;

    // Sequencer and architectural state
    seq_t            st_reg, st_next;
    logic [7:0]      lo_reg, lo_next;
    logic [7:0]      hi_reg, hi_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [SW-1:0]   cursor_reg, cursor_next;
    logic [SW-1:0]   match_reg, match_next;
    logic [SW:0]     node_cnt_reg, node_cnt_next;
    logic [WCW-1:0]  word_cnt_reg, word_cnt_next;
    logic [GW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            clr_report_reg, clr_report_next;
    // Failure walk
    logic [SW-1:0]   adv_s_reg, adv_s_next;
    logic [SW:0]     steps_reg, steps_next;
    logic            adv_build_reg, adv_build_next;
    // Breadth-first build
    logic [SW:0]     head_reg, head_next;
    logic [SW:0]     tail_reg, tail_next;
    logic [SW-1:0]   bs_reg, bs_next;
    logic [SW-1:0]   bfs_fs_reg, bfs_fs_next;
    logic [CW-1:0]   bcol_reg, bcol_next;
    logic [SW-1:0]   ch_reg, ch_next;
    logic [SW-1:0]   f_reg, f_next;
    logic [MW-1:0]   mask_tmp_reg, mask_tmp_next;
    // Pending result
    logic [SW-1:0]   res_st_reg, res_st_next;
    logic [MW-1:0]   res_mask_reg, res_mask_next;
    logic [1:0]      res_status_reg, res_status_next;
    // Output register
    mpsm_pkg::result_t out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    // Memories
    logic [SW-1:0] goto_mem [GDEPTH];
    logic [SW-1:0] fail_mem [MAX_STATES];
    logic [MW-1:0] mask_mem [MAX_STATES];
    logic [SW-1:0] queue_mem [MAX_STATES];

    logic          goto_we;
    logic [GW-1:0] goto_waddr, goto_addr;
    logic [SW-1:0] goto_wdata, goto_rdata;
    logic          fail_we;
    logic [SW-1:0] fail_waddr, fail_raddr, fail_wdata, fail_rdata;
    logic          mask_we;
    logic [SW-1:0] mask_waddr, mask_raddr;
    logic [MW-1:0] mask_wdata, mask_rdata;
    logic          queue_we;
    logic [SW-1:0] queue_wdata, queue_rdata;

    // Symbol mapping and goto address
    logic [7:0]    sym_diff;
    logic          span_ok;
    logic [CW-1:0] sym_col;
    logic [SW-1:0] row_sel;
    logic [CW-1:0] col_sel;
    logic [SW:0]   steps_inc;
    logic          clr_low;
    logic          item_fire;

    assign sym_diff = item.symbol - lo_reg;
    assign span_ok  = (item.symbol >= lo_reg) && (item.symbol <= hi_reg)
                      && ({1'b0, sym_diff} < ALPHA_9);
    assign sym_col  = sym_diff[CW-1:0];

    assign row_sel = (st_reg == S_ADV_RD) ? adv_s_reg :
                     (st_reg == S_BR_RD)  ? '0 :
                     (st_reg == S_BC_RD)  ? bs_reg : cursor_reg;
    assign col_sel = (st_reg == S_BR_RD || st_reg == S_BC_RD) ? bcol_reg : col_reg;
    assign goto_addr = GW'(row_sel) * ALPHA_G + GW'(col_sel);

    assign steps_inc = steps_reg + 1'b1;
    assign clr_low   = clr_cnt_reg < STATES_G;

    assign item_ready   = (st_reg == S_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // Memory port selection
    always_comb
    begin
        goto_we     = 1'b0;
        goto_waddr  = goto_addr;
        goto_wdata  = node_cnt_reg[SW-1:0];
        fail_we     = 1'b0;
        fail_waddr  = ch_reg;
        fail_wdata  = '0;
        fail_raddr  = (st_reg == S_BQ_F) ? bs_reg : adv_s_reg;
        mask_we     = 1'b0;
        mask_waddr  = ch_reg;
        mask_wdata  = mask_rdata | mask_tmp_reg;
        mask_raddr  = (st_reg == S_EK_RD) ? cursor_reg :
                      (st_reg == S_MD)    ? ch_reg : f_reg;
        queue_we    = 1'b0;
        queue_wdata = ch_reg;

        if (st_reg == S_CLR)
        begin
            goto_we    = 1'b1;
            goto_waddr = clr_cnt_reg;
            goto_wdata = '0;
            fail_we    = clr_low;
            fail_waddr = clr_cnt_reg[SW-1:0];
            mask_we    = clr_low;
            mask_waddr = clr_cnt_reg[SW-1:0];
            mask_wdata = '0;
        end
        if (st_reg == S_KW_WR && goto_rdata == '0 && node_cnt_reg < STATES_N)
        begin
            goto_we    = 1'b1;
            fail_we    = 1'b1;
            fail_waddr = node_cnt_reg[SW-1:0];
        end
        if (st_reg == S_EK_WR)
        begin
            mask_we    = 1'b1;
            mask_waddr = cursor_reg;
            mask_wdata = mask_rdata | (MW'(1) << word_cnt_reg);
        end
        if (st_reg == S_BR_CHK && goto_rdata != '0 && tail_reg < STATES_N)
        begin
            fail_we     = 1'b1;
            fail_waddr  = goto_rdata;
            queue_we    = 1'b1;
            queue_wdata = goto_rdata;
        end
        if (st_reg == S_MD && adv_build_reg)
        begin
            fail_we    = 1'b1;
            fail_wdata = f_reg;
        end
        if (st_reg == S_BM_CD)
        begin
            mask_we  = 1'b1;
            queue_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (goto_we)
        begin
            goto_mem[goto_waddr] <= goto_wdata;
        end
        goto_rdata <= goto_mem[goto_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fail_rdata <= fail_mem[fail_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        mask_rdata <= mask_mem[mask_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
        begin
            queue_mem[tail_reg[SW-1:0]] <= queue_wdata;
        end
        queue_rdata <= queue_mem[head_reg[SW-1:0]];
    end

    // Sequencer
    always_comb
    begin
        st_next         = st_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        col_next        = col_reg;
        cursor_next     = cursor_reg;
        match_next      = match_reg;
        node_cnt_next   = node_cnt_reg;
        word_cnt_next   = word_cnt_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        adv_s_next      = adv_s_reg;
        steps_next      = steps_reg;
        adv_build_next  = adv_build_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        bs_next         = bs_reg;
        bfs_fs_next     = bfs_fs_reg;
        bcol_next       = bcol_reg;
        ch_next         = ch_reg;
        f_next          = f_reg;
        mask_tmp_next   = mask_tmp_reg;
        res_st_next     = res_st_reg;
        res_mask_next   = res_mask_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (cfg_valid)
        begin
            if (cfg_index == mpsm_pkg::REG_LOWEST)
            begin
                lo_next = cfg_data;
            end
            else
            begin
                hi_next = cfg_data;
            end
        end

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    res_mask_next   = '0;
                    res_status_next = mpsm_pkg::STAT_OK;
                    res_st_next     = match_reg;
                    st_next         = S_FIN;
                    col_next        = sym_col;
                    unique case (item.kind)
                        mpsm_pkg::KIND_CLEAR:
                        begin
                            clr_cnt_next    = '0;
                            clr_report_next = 1'b1;
                            st_next         = S_CLR;
                        end
                        mpsm_pkg::KIND_KEY:
                        begin
                            res_st_next = cursor_reg;
                            if (span_ok)
                            begin
                                st_next = S_KW_RD;
                            end
                            else
                            begin
                                res_status_next = mpsm_pkg::STAT_SPAN;
                            end
                        end
                        mpsm_pkg::KIND_END:
                        begin
                            res_st_next = cursor_reg;
                            if (word_cnt_reg >= WORDS_N)
                            begin
                                res_status_next = mpsm_pkg::STAT_WORDS;
                            end
                            else
                            begin
                                st_next = S_EK_RD;
                            end
                        end
                        mpsm_pkg::KIND_BUILD:
                        begin
                            bcol_next = '0;
                            head_next = '0;
                            tail_next = '0;
                            st_next   = S_BR_RD;
                        end
                        mpsm_pkg::KIND_TEXT:
                        begin
                            if (span_ok)
                            begin
                                adv_s_next     = match_reg;
                                steps_next     = '0;
                                adv_build_next = 1'b0;
                                st_next        = S_ADV_RD;
                            end
                            else
                            begin
                                res_status_next = mpsm_pkg::STAT_SPAN;
                            end
                        end
                        default:
                        begin
                            // unused kinds report the match state and change nothing
                        end
                    endcase
                end
            end

            S_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    node_cnt_next   = (SW + 1)'(1);
                    word_cnt_next   = '0;
                    cursor_next     = '0;
                    match_next      = '0;
                    res_st_next     = '0;
                    clr_report_next = 1'b0;
                    st_next         = clr_report_reg ? S_FIN : S_IDLE;
                end
            end

            S_KW_RD:
            begin
                st_next = S_KW_WR;
            end

            S_KW_WR:
            begin
                st_next = S_FIN;
                if (goto_rdata != '0)
                begin
                    cursor_next = goto_rdata;
                    res_st_next = goto_rdata;
                end
                else if (node_cnt_reg >= STATES_N)
                begin
                    res_status_next = mpsm_pkg::STAT_FULL;
                end
                else
                begin
                    cursor_next   = node_cnt_reg[SW-1:0];
                    res_st_next   = node_cnt_reg[SW-1:0];
                    node_cnt_next = node_cnt_reg + 1'b1;
                end
            end

            S_EK_RD:
            begin
                st_next = S_EK_WR;
            end

            S_EK_WR:
            begin
                word_cnt_next = word_cnt_reg + 1'b1;
                cursor_next   = '0;
                res_st_next   = '0;
                st_next       = S_FIN;
            end

            S_ADV_RD:
            begin
                st_next = S_ADV_CHK;
            end

            S_ADV_CHK:
            begin
                if (goto_rdata != '0 || adv_s_reg == '0)
                begin
                    f_next  = goto_rdata;
                    st_next = S_MR;
                    if (!adv_build_reg)
                    begin
                        match_next  = goto_rdata;
                        res_st_next = goto_rdata;
                    end
                end
                else
                begin
                    steps_next = steps_inc;
                    if (steps_inc >= STATES_N)
                    begin
                        adv_s_next = '0;
                        st_next    = S_ADV_RD;
                    end
                    else
                    begin
                        st_next = S_FAIL_CHK;
                    end
                end
            end

            S_FAIL_CHK:
            begin
                adv_s_next = fail_rdata;
                st_next    = S_ADV_RD;
            end

            S_MR:
            begin
                st_next = S_MD;
            end

            S_MD:
            begin
                if (adv_build_reg)
                begin
                    mask_tmp_next = mask_rdata;
                    st_next       = S_BM_CD;
                end
                else
                begin
                    res_mask_next = mask_rdata;
                    st_next       = S_FIN;
                end
            end

            S_BM_CD:
            begin
                tail_next = tail_reg + 1'b1;
                if (bcol_reg == COL_LAST)
                begin
                    st_next = S_BQ_CHK;
                end
                else
                begin
                    bcol_next = bcol_reg + 1'b1;
                    st_next   = S_BC_RD;
                end
            end

            S_BR_RD:
            begin
                st_next = S_BR_CHK;
            end

            S_BR_CHK:
            begin
                if (goto_rdata != '0 && tail_reg < STATES_N)
                begin
                    tail_next = tail_reg + 1'b1;
                end
                if (bcol_reg == COL_LAST)
                begin
                    st_next = S_BQ_CHK;
                end
                else
                begin
                    bcol_next = bcol_reg + 1'b1;
                    st_next   = S_BR_RD;
                end
            end

            S_BQ_CHK:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next = head_reg + 1'b1;
                    st_next   = S_BQ_S;
                end
                else
                begin
                    match_next  = '0;
                    cursor_next = '0;
                    res_st_next = '0;
                    st_next     = S_FIN;
                end
            end

            S_BQ_S:
            begin
                bs_next = queue_rdata;
                st_next = S_BQ_F;
            end

            S_BQ_F:
            begin
                st_next = S_BQ_FS;
            end

            S_BQ_FS:
            begin
                bfs_fs_next = fail_rdata;
                bcol_next   = '0;
                st_next     = S_BC_RD;
            end

            S_BC_RD:
            begin
                st_next = S_BC_CHK;
            end

            S_BC_CHK:
            begin
                if (goto_rdata != '0 && tail_reg < STATES_N)
                begin
                    ch_next        = goto_rdata;
                    col_next       = bcol_reg;
                    adv_s_next     = bfs_fs_reg;
                    steps_next     = '0;
                    adv_build_next = 1'b1;
                    st_next        = S_ADV_RD;
                end
                else if (bcol_reg == COL_LAST)
                begin
                    st_next = S_BQ_CHK;
                end
                else
                begin
                    bcol_next = bcol_reg + 1'b1;
                    st_next   = S_BC_RD;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.state       = 8'(res_st_reg);
                    out_next.match_mask  = 32'(res_mask_reg);
                    out_next.state_count = 9'(node_cnt_reg);
                    out_next.status      = res_status_reg;
                    out_valid_next       = 1'b1;
                    st_next              = S_IDLE;
                end
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_CLR;
            lo_reg         <= mpsm_pkg::LOWEST_CHAR_RST;
            hi_reg         <= mpsm_pkg::HIGHEST_CHAR_RST;
            cursor_reg     <= '0;
            match_reg      <= '0;
            node_cnt_reg   <= (SW + 1)'(1);
            word_cnt_reg   <= '0;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            steps_reg      <= '0;
            adv_build_reg  <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            cursor_reg     <= cursor_next;
            match_reg      <= match_next;
            node_cnt_reg   <= node_cnt_next;
            word_cnt_reg   <= word_cnt_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            steps_reg      <= steps_next;
            adv_build_reg  <= adv_build_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        adv_s_reg      <= adv_s_next;
        bs_reg         <= bs_next;
        bfs_fs_reg     <= bfs_fs_next;
        bcol_reg       <= bcol_next;
        ch_reg         <= ch_next;
        f_reg          <= f_next;
        mask_tmp_reg   <= mask_tmp_next;
        res_st_reg     <= res_st_next;
        res_mask_reg   <= res_mask_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire
